>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> sv/cicc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cicc_pkg
// Control word, step codes and microprogram of the interval cover counter.
// ----------------------------------------------------------------------------
package cicc_pkg;

	localparam int POS_BITS   = 16;
	localparam int IDX_BITS   = 10;
	localparam int CNT_OUT_W  = 32;
	localparam int TOUCH_W    = 11;

	typedef enum logic [3:0] {
		S_CLR   = 4'd0,
		S_IDLE  = 4'd1,
		S_DISP  = 4'd2,
		S_BIN   = 4'd3,
		S_TEST  = 4'd4,
		S_INC   = 4'd5,
		S_ADONE = 4'd6,
		S_RD    = 4'd7,
		S_RDONE = 4'd8
	} step_t;

	localparam step_t S_LAST = S_RDONE;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NOT_I_LAST,
		C_NOT_START,
		C_OP_READ,
		C_I_EQ_STOP,
		C_NEXT
	} cond_t;

	typedef enum logic [1:0] {
		I_HOLD,
		I_CLR,
		I_LOAD,
		I_WALK
	} i_op_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		logic  idle;
		logic  clr_wr;
		i_op_t i_op;
		logic  ld_dir;
		logic  rd_walk;
		logic  rd_idx;
		logic  inc_wr;
		logic  done_add;
		logic  done_rd;
	} ctrl_t;

	typedef struct packed {
		logic i_last;
		logic i_eq_stop;
		logic op_read;
	} status_t;

	function automatic ctrl_t rom(step_t s);
		ctrl_t w;
		w = '{cond: C_ALWAYS, target: S_IDLE, idle: 1'b0, clr_wr: 1'b0, i_op: I_HOLD,
			ld_dir: 1'b0, rd_walk: 1'b0, rd_idx: 1'b0, inc_wr: 1'b0,
			done_add: 1'b0, done_rd: 1'b0};
		unique case (s)
			S_CLR: begin
				w.cond   = C_NOT_I_LAST;
				w.target = S_CLR;
				w.clr_wr = 1'b1;
				w.i_op   = I_CLR;
			end
			S_IDLE: begin
				w.cond   = C_NOT_START;
				w.target = S_IDLE;
				w.idle   = 1'b1;
			end
			S_DISP: begin
				w.cond   = C_OP_READ;
				w.target = S_RD;
				w.ld_dir = 1'b1;
			end
			S_BIN: begin
				w.cond = C_NEXT;
				w.i_op = I_LOAD;
			end
			S_TEST: begin
				w.cond    = C_I_EQ_STOP;
				w.target  = S_ADONE;
				w.rd_walk = 1'b1;
			end
			S_INC: begin
				w.cond   = C_ALWAYS;
				w.target = S_TEST;
				w.inc_wr = 1'b1;
				w.i_op   = I_WALK;
			end
			S_ADONE: begin
				w.done_add = 1'b1;
			end
			S_RD: begin
				w.cond   = C_NEXT;
				w.rd_idx = 1'b1;
			end
			S_RDONE: begin
				w.done_rd = 1'b1;
			end
			default: begin
				w.cond = C_ALWAYS;
			end
		endcase
		return w;
	endfunction

endpackage

>>> sv/cicc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cicc_seq
// Step counter and microprogram table with conditional jumps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cicc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cicc_pkg::status_t status,
	output cicc_pkg::ctrl_t   ctrl
);

	cicc_pkg::step_t pc_q;
	logic            jump;

	assign ctrl = cicc_pkg::rom(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			cicc_pkg::C_ALWAYS:     jump = 1'b1;
			cicc_pkg::C_NOT_I_LAST: jump = !status.i_last;
			cicc_pkg::C_NOT_START:  jump = !start;
			cicc_pkg::C_OP_READ:    jump = status.op_read;
			cicc_pkg::C_I_EQ_STOP:  jump = status.i_eq_stop;
			cicc_pkg::C_NEXT:       jump = 1'b0;
			default:                jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= cicc_pkg::S_CLR;
		end else if (jump) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= cicc_pkg::step_t'(pc_q + 4'd1);
		end
	end

	`ASSERT_NEVER(a_pc_range, clk, arst_n, pc_q > cicc_pkg::S_LAST)
	`ASSERT_AT(a_accept_dispatch, clk, arst_n, (ctrl.idle && start) |=> pc_q == cicc_pkg::S_DISP)
	`ASSERT_AT(a_done_to_idle, clk, arst_n, (ctrl.done_add || ctrl.done_rd) |=> pc_q == cicc_pkg::S_IDLE)

endmodule

>>> sv/cicc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cicc_dp
// Datapath: position registers, bin rounding, walk index and counter memory.
// ----------------------------------------------------------------------------
module cicc_dp #(
	parameter int BINS       = 1024,
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cicc_pkg::ctrl_t                   ctrl,
	input  logic                              start,
	input  logic                              opcode,
	input  logic [cicc_pkg::POS_BITS-1:0]     start_pos,
	input  logic [cicc_pkg::POS_BITS-1:0]     end_pos,
	input  logic [cicc_pkg::IDX_BITS-1:0]     read_index,
	input  logic                              cfg_valid,
	input  logic [cicc_pkg::POS_BITS-1:0]     cfg_data,
	output cicc_pkg::status_t                 status,
	output logic                              done,
	output logic [cicc_pkg::CNT_OUT_W-1:0]    bin_count,
	output logic [cicc_pkg::TOUCH_W-1:0]      bins_touched
);

	localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int BW = $clog2(BINS + 1);
	localparam int PB = cicc_pkg::POS_BITS;
	localparam int SW = PB + BW;
	localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);
	localparam logic [SW-1:0] ROUND_UP = SW'({PB{1'b1}});

	logic [PB-1:0]                    origin_q;
	logic                             op_q;
	logic [cicc_pkg::IDX_BITS-1:0]    ridx_q;
	logic [PB-1:0]                    rs_q;
	logic [PB-1:0]                    re_q;
	logic                             up_q;
	logic [SW-1:0]                    srs_q;
	logic [SW-1:0]                    sre_q;
	logic [AW-1:0]                    i_q;
	logic [AW-1:0]                    stop_q;
	logic [AW-1:0]                    touched_q;
	logic [COUNT_BITS-1:0]            rdata_q;
	logic                             done_q;
	logic [cicc_pkg::CNT_OUT_W-1:0]   bin_count_q;
	logic [cicc_pkg::TOUCH_W-1:0]     bins_touched_q;
	logic [COUNT_BITS-1:0]            mem [BINS];

	logic                             accept;
	logic                             fwd;
	logic [PB-1:0]                    span;
	logic                             up_dir;
	logic [AW-1:0]                    i_walk;
	logic [AW-1:0]                    i_clr;
	logic [AW-1:0]                    bin_start;
	logic [AW-1:0]                    bin_stop;
	logic                             we;
	logic [AW-1:0]                    ra;
	logic [COUNT_BITS-1:0]            wd;
	logic [COUNT_BITS-1:0]            sat_inc;
	logic                             ridx_ok;

	function automatic logic [AW-1:0] near_bin(logic [SW-1:0] scaled, logic up);
		logic [SW-1:0] sum;
		logic [BW-1:0] idx;
		sum = up ? (scaled + ROUND_UP) : scaled;
		idx = sum[SW-1:PB];
		if (32'(idx) >= BINS) begin
			idx = '0;
		end
		return AW'(idx);
	endfunction

	assign accept  = ctrl.idle && start;
	assign fwd     = rs_q <= re_q;
	assign span    = fwd ? (re_q - rs_q) : (rs_q - re_q);
	assign up_dir  = (span > PB'(1 << (PB - 1))) ? !fwd : fwd;

	assign i_clr   = (i_q == LAST_BIN) ? '0 : i_q + AW'(1);
	assign i_walk  = up_q ? i_clr : ((i_q == '0) ? LAST_BIN : i_q - AW'(1));

	assign bin_start = near_bin(srs_q, up_q);
	assign bin_stop  = near_bin(sre_q, up_q);

	assign sat_inc = (&rdata_q) ? rdata_q : rdata_q + COUNT_BITS'(1);
	assign we      = ctrl.clr_wr || ctrl.inc_wr;
	assign wd      = ctrl.clr_wr ? '0 : sat_inc;
	assign ra      = ctrl.rd_idx ? AW'(ridx_q) : i_q;
	assign ridx_ok = 32'(ridx_q) < BINS;

	assign status.i_last    = i_q == LAST_BIN;
	assign status.i_eq_stop = i_q == stop_q;
	assign status.op_read   = op_q;

	assign done         = done_q;
	assign bin_count    = bin_count_q;
	assign bins_touched = bins_touched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			i_q      <= '0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				origin_q <= cfg_data;
			end
			unique case (ctrl.i_op)
				cicc_pkg::I_HOLD: i_q <= i_q;
				cicc_pkg::I_CLR:  i_q <= i_clr;
				cicc_pkg::I_LOAD: i_q <= bin_start;
				cicc_pkg::I_WALK: i_q <= i_walk;
				default:          i_q <= i_q;
			endcase
			done_q <= ctrl.done_add || ctrl.done_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			ridx_q <= read_index;
			rs_q   <= start_pos - origin_q;
			re_q   <= end_pos - origin_q;
		end
		if (ctrl.ld_dir) begin
			up_q  <= up_dir;
			srs_q <= SW'(rs_q) * SW'(BINS);
			sre_q <= SW'(re_q) * SW'(BINS);
		end
		if (ctrl.i_op == cicc_pkg::I_LOAD) begin
			stop_q    <= bin_stop;
			touched_q <= '0;
		end else if (ctrl.inc_wr) begin
			touched_q <= touched_q + AW'(1);
		end
		if (ctrl.done_add) begin
			bin_count_q    <= '0;
			bins_touched_q <= cicc_pkg::TOUCH_W'(touched_q);
		end else if (ctrl.done_rd) begin
			bin_count_q    <= ridx_ok ? cicc_pkg::CNT_OUT_W'(rdata_q) : '0;
			bins_touched_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[i_q] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_walk || ctrl.rd_idx) begin
			rdata_q <= mem[ra];
		end
	end

endmodule

>>> sv/circular_interval_cover_counter_top.sv
`timescale 1ns / 1ps
// Sequence: a read steps through dispatch, an indexed read and its done step; an add
// steps through dispatch and bin load, then a test and an increment step per walked bin
// (n walked bins, n <= BINS/2) and a done step. Items are taken one at a time; each walked
// bin is read and then written back in the counter memory. busy is low again in the cycle done is shown.
// Reset: all counters are cleared by a sweep over all BINS bins with busy held high;
// range_origin resets to 0. The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
// circular_interval_cover_counter_top
// Ring of saturating bin counters updated by shortest-way interval walks.
// ----------------------------------------------------------------------------
module circular_interval_cover_counter_top #(
	parameter int BINS       = 1024,
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic [cicc_pkg::POS_BITS-1:0]     start_pos,
	input  logic [cicc_pkg::POS_BITS-1:0]     end_pos,
	input  logic [cicc_pkg::IDX_BITS-1:0]     read_index,
	output logic                              done,
	output logic [cicc_pkg::CNT_OUT_W-1:0]    bin_count,
	output logic [cicc_pkg::TOUCH_W-1:0]      bins_touched,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cicc_pkg::POS_BITS-1:0]     cfg_data
);

	cicc_pkg::ctrl_t   ctrl;
	cicc_pkg::status_t status;

	assign busy      = !ctrl.idle;
	assign cfg_ready = 1'b1;

	cicc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl)
	);

	cicc_dp #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.start        (start),
		.opcode       (opcode),
		.start_pos    (start_pos),
		.end_pos      (end_pos),
		.read_index   (read_index),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.status       (status),
		.done         (done),
		.bin_count    (bin_count),
		.bins_touched (bins_touched)
	);

endmodule

>>> verif/cicc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cicc_tb_pkg
// Operation codes and result record shared by the cover counter testbench.
// ----------------------------------------------------------------------------
package cicc_tb_pkg;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_READ = 1'b1
	} cover_op_t;

	typedef struct packed {
		logic [cicc_pkg::CNT_OUT_W-1:0] count;
		logic [cicc_pkg::TOUCH_W-1:0]   touched;
	} bin_report_t;

endpackage

>>> verif/cicc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cicc_checker
// Watches item, result and origin transfers of the interval cover counter,
// keeps its own ring of bin counters, and compares every result in order.
// ----------------------------------------------------------------------------
module cicc_checker #(
	parameter int BINS       = 1024,
	parameter int COUNT_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           opcode,
	input  logic [cicc_pkg::POS_BITS-1:0]  start_pos,
	input  logic [cicc_pkg::POS_BITS-1:0]  end_pos,
	input  logic [cicc_pkg::IDX_BITS-1:0]  read_index,
	input  logic                           done,
	input  logic [cicc_pkg::CNT_OUT_W-1:0] bin_count,
	input  logic [cicc_pkg::TOUCH_W-1:0]   bins_touched,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [cicc_pkg::POS_BITS-1:0]  cfg_data,
	output int                             fail_count,
	output int                             pending
);

	localparam int PB = cicc_pkg::POS_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0]     cover_counts [BINS];
	logic [PB-1:0]             range_origin;
	cicc_tb_pkg::bin_report_t  bin_reports_q [$];
	cicc_tb_pkg::bin_report_t  oldest_report;
	int                        mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t cover check: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic int nearest_bin(logic [PB-1:0] rel, bit up);
		longint unsigned scaled;
		longint unsigned idx;
		scaled = 64'(rel);
		scaled = scaled * BINS;
		if (up) begin
			idx = (scaled + ((64'd1 << PB) - 1)) >> PB;
		end else begin
			idx = scaled >> PB;
		end
		return (idx >= BINS) ? 0 : int'(idx);
	endfunction

	function automatic cicc_tb_pkg::bin_report_t predict_cover_step(bit is_read,
			logic [PB-1:0] s_pos, logic [PB-1:0] e_pos,
			logic [cicc_pkg::IDX_BITS-1:0] idx);
		cicc_tb_pkg::bin_report_t rep;
		logic [PB-1:0] rs;
		logic [PB-1:0] re;
		logic [PB-1:0] span;
		bit up;
		int i;
		int stop;
		int touched;
		rep = '0;
		touched = 0;
		if (is_read) begin
			if (idx < BINS) begin
				rep.count = cicc_pkg::CNT_OUT_W'(cover_counts[idx]);
			end
		end else begin
			rs = s_pos - range_origin;
			re = e_pos - range_origin;
			up = (rs <= re);
			span = up ? re - rs : rs - re;
			if (span > (1 << (PB - 1))) begin
				up = !up;
			end
			i = nearest_bin(rs, up);
			stop = nearest_bin(re, up);
			while (i != stop) begin
				if (cover_counts[i] != COUNT_MAX) begin
					cover_counts[i] = cover_counts[i] + 1'b1;
				end
				touched++;
				if (up) begin
					i = (i == BINS - 1) ? 0 : i + 1;
				end else begin
					i = (i == 0) ? BINS - 1 : i - 1;
				end
			end
			rep.touched = cicc_pkg::TOUCH_W'(touched);
		end
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (cover_counts[k]) begin
				cover_counts[k] = '0;
			end
			range_origin = '0;
			bin_reports_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (bin_reports_q.size() == 0) begin
					report_mismatch("result with no item outstanding, bin_count",
						64'(bin_count), 64'd0);
				end else begin
					oldest_report = bin_reports_q.pop_front();
					if (bin_count !== oldest_report.count) begin
						report_mismatch("bin_count", 64'(bin_count),
							64'(oldest_report.count));
					end
					if (bins_touched !== oldest_report.touched) begin
						report_mismatch("bins_touched", 64'(bins_touched),
							64'(oldest_report.touched));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				range_origin = cfg_data;
			end
			if (start && !busy) begin
				bin_reports_q.push_back(predict_cover_step(
					opcode == cicc_tb_pkg::OP_READ, start_pos, end_pos, read_index));
			end
			pending <= bin_reports_q.size();
		end
	end

endmodule

>>> verif/tb_circular_interval_cover_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_interval_cover_counter_top
// Drives interval adds and bin reads through several range origins, with
// directed edge cases first and random intervals after, and idles at random.
// A separate checker predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_circular_interval_cover_counter_top;

	localparam int BINS           = 1024;
	localparam int COUNT_BITS     = 32;
	localparam int WATCHDOG_LIMIT = 16000;
	localparam int RANDOM_PHASES  = 7;
	localparam int PHASE_ITEMS    = 83;
	localparam logic [15:0] HALF_PERIOD = 16'h8000;
	localparam logic [15:0] BIN_WIDTH   = 16'd64;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic        busy;
	logic        opcode     = cicc_tb_pkg::OP_ADD;
	logic [15:0] start_pos  = '0;
	logic [15:0] end_pos    = '0;
	logic [9:0]  read_index = '0;
	logic        done;
	logic [31:0] bin_count;
	logic [10:0] bins_touched;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data   = '0;

	int          fail_count;
	int          pending;
	int          quiet_cycles = 0;
	bit          no_gaps = 1'b0;
	logic [15:0] cur_origin = '0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	circular_interval_cover_counter_top #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.start_pos    (start_pos),
		.end_pos      (end_pos),
		.read_index   (read_index),
		.done         (done),
		.bin_count    (bin_count),
		.bins_touched (bins_touched),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	cicc_checker #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.start_pos    (start_pos),
		.end_pos      (end_pos),
		.read_index   (read_index),
		.done         (done),
		.bin_count    (bin_count),
		.bins_touched (bins_touched),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
		$display("tb_circular_interval_cover_counter_top: FAIL");
		$finish;
	end

	task automatic idle_gap();
		int pick;
		int n;
		n = 0;
		if (!no_gaps) begin
			pick = $urandom_range(0, 9);
			if (pick >= 9) begin
				n = $urandom_range(8, 40);
			end else if (pick >= 5) begin
				n = $urandom_range(1, 3);
			end
		end
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue_item(cicc_tb_pkg::cover_op_t op, logic [15:0] s, logic [15:0] e,
			logic [9:0] idx);
		idle_gap();
		start      <= 1'b1;
		opcode     <= op;
		start_pos  <= s;
		end_pos    <= e;
		read_index <= idx;
		do @(posedge clk); while (busy);
	endtask

	// drain outstanding results, then transfer a new origin
	task automatic write_origin(logic [15:0] value);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat ($urandom_range(4, 12)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		cur_origin = value;
	endtask

	task automatic random_add();
		logic [15:0] s;
		logic [15:0] d;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			s = cur_origin - 16'($urandom_range(1, 64));
		end else if (pick < 30) begin
			s = cur_origin + (16'($urandom_range(0, BINS - 1)) * BIN_WIDTH)
				+ 16'($urandom_range(0, 2)) - 16'd1;
		end else begin
			s = 16'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			d = 16'($urandom_range(0, 2048));
		end else if (pick < 55) begin
			d = HALF_PERIOD - 16'd64 + 16'($urandom_range(0, 128));
		end else if (pick < 65) begin
			d = 16'($urandom_range(0, BINS - 1)) * BIN_WIDTH;
		end else begin
			d = 16'($urandom);
		end
		if ($urandom_range(0, 1) == 1) begin
			d = -d;
		end
		issue_item(cicc_tb_pkg::OP_ADD, s, s + d, 10'($urandom));
	endtask

	initial begin
		logic [15:0] phase_origin;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_origin(16'h0000);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd0, 16'd0, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd0, 16'hFFFF, 10'h3FF);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd0, HALF_PERIOD, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd0, HALF_PERIOD + 16'd1, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, HALF_PERIOD, 16'd0, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'hFFFF, 16'd64, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd65500, 16'hFFFF, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd100, 16'd30, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd64, 16'd128, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'hFFFF, 16'd0, 10'd0);
		issue_item(cicc_tb_pkg::OP_READ, 16'hFFFF, 16'hFFFF, 10'd0);
		issue_item(cicc_tb_pkg::OP_READ, 16'd0, 16'd0, 10'h3FF);
		issue_item(cicc_tb_pkg::OP_READ, 16'd0, 16'd0, 10'd512);
		issue_item(cicc_tb_pkg::OP_READ, 16'd0, 16'd0, 10'd511);
		issue_item(cicc_tb_pkg::OP_READ, 16'd0, 16'd0, 10'd1);

		write_origin(16'hFFFF);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd0, 16'hFFFF, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'hFFFF, 16'd0, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'h7FFF, 16'hFFFF, 10'd0);
		issue_item(cicc_tb_pkg::OP_ADD, 16'd12345, 16'd54321, 10'd0);
		issue_item(cicc_tb_pkg::OP_READ, 16'd0, 16'd0, 10'd0);
		issue_item(cicc_tb_pkg::OP_READ, 16'd0, 16'd0, 10'h3FF);
		issue_item(cicc_tb_pkg::OP_READ, 16'd0, 16'd0, 10'd256);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: phase_origin = 16'h8000;
				2: phase_origin = 16'h0001;
				4: phase_origin = 16'h7FFF;
				6: phase_origin = 16'h0000;
				default: phase_origin = 16'($urandom);
			endcase
			write_origin(phase_origin);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 7) begin
					random_add();
				end else begin
					issue_item(cicc_tb_pkg::OP_READ, 16'($urandom), 16'($urandom),
						10'($urandom_range(0, BINS - 1)));
				end
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_circular_interval_cover_counter_top: PASS");
		end else begin
			$display("tb_circular_interval_cover_counter_top: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/cicc_pkg.sv
sv/cicc_seq.sv
sv/cicc_dp.sv
sv/circular_interval_cover_counter_top.sv
verif/cicc_tb_pkg.sv
verif/cicc_checker.sv
verif/tb_circular_interval_cover_counter_top.sv
